// ----- rtl/core/watering_pump_sequencer_assert.svh -----
// Assertion macros for the watering pump sequencer checks
`ifndef WATERING_PUMP_SEQUENCER_ASSERT_SVH
`define WATERING_PUMP_SEQUENCER_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define WPS_ASSERT_HOLD(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("watering_pump_sequencer: check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define WPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("watering_pump_sequencer: check failed");

`endif

// ----- rtl/core/wps_pkg.sv -----
// Types and constants shared by the watering pump sequencer files
`default_nettype none
package wps_pkg;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int WAIT_W = 12;
	localparam int SUM_W  = 12;

	typedef enum logic [1:0] {
		REG_SETUP_LIMIT   = 2'd0,
		REG_IDLE_TICKS    = 2'd1,
		REG_SETTLE_TICKS  = 2'd2,
		REG_FAILURE_LIMIT = 2'd3
	} reg_idx_t;

	localparam logic [7:0]  SETUP_LIMIT_RST   = 8'd80;
	localparam logic [11:0] IDLE_TICKS_RST    = 12'd256;
	localparam logic [7:0]  SETTLE_TICKS_RST  = 8'd1;
	localparam logic [3:0]  FAILURE_LIMIT_RST = 4'd2;

	localparam logic [3:0] FAIL_MAX = 4'd15;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_BUTTON = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [5:0] {
		PH_WAIT   = 6'b000001,
		PH_SETUP  = 6'b000010,
		PH_SETTLE = 6'b000100,
		PH_SAMPLE = 6'b001000,
		PH_PUMP   = 6'b010000,
		PH_IDLE   = 6'b100000
	} phase_t;

	localparam logic [2:0] CODE_WAIT   = 3'd0;
	localparam logic [2:0] CODE_SETUP  = 3'd1;
	localparam logic [2:0] CODE_SETTLE = 3'd2;
	localparam logic [2:0] CODE_SAMPLE = 3'd3;
	localparam logic [2:0] CODE_PUMP   = 3'd4;
	localparam logic [2:0] CODE_IDLE   = 3'd5;

	typedef struct packed {
		logic [7:0]  setup_limit;
		logic [11:0] idle_ticks;
		logic [7:0]  settle_ticks;
		logic [3:0]  failure_limit;
	} cfg_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] sample;
		logic       button_pressed;
	} evt_t;

	typedef struct packed {
		logic       pump_drive;
		logic       sensor_drive;
		logic       sampling;
		logic [2:0] phase_code;
		logic [7:0] level;
		logic [7:0] goal_level;
	} stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/wps_cfg.sv -----
// APB-style configuration register file of the watering pump sequencer
`default_nettype none
module wps_cfg
	import wps_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setup_limit   <= SETUP_LIMIT_RST;
			cfg_q.idle_ticks    <= IDLE_TICKS_RST;
			cfg_q.settle_ticks  <= SETTLE_TICKS_RST;
			cfg_q.failure_limit <= FAILURE_LIMIT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_SETUP_LIMIT:   cfg_q.setup_limit   <= pwdata[7:0];
				REG_IDLE_TICKS:    cfg_q.idle_ticks    <= pwdata[11:0];
				REG_SETTLE_TICKS:  cfg_q.settle_ticks  <= pwdata[7:0];
				REG_FAILURE_LIMIT: cfg_q.failure_limit <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SETUP_LIMIT:   prdata = {24'd0, cfg_q.setup_limit};
			REG_IDLE_TICKS:    prdata = {20'd0, cfg_q.idle_ticks};
			REG_SETTLE_TICKS:  prdata = {24'd0, cfg_q.settle_ticks};
			REG_FAILURE_LIMIT: prdata = {28'd0, cfg_q.failure_limit};
			default:           prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/watering_pump_sequencer.sv -----
// Watering pump sequencer top level: event register, phase update, status register
//
//  channel | direction | handshake           | beat
//  evt     | in        | evt_valid/evt_ready | op, sample, button_pressed
//  stat    | out       | stat_valid/stat_ready | drives, phase_code, level, goal_level
//  apb     | in        | psel/penable/pready | register write or read
//
// One beat per cycle sustained while the status output is not stalled; a beat passes the event
// register, then the status register, set by the combinational phase update.
// arst_n clears the phase state and loads the register reset values.
// A stalled status beat holds in its register; the event register still takes a beat
// while it is empty or moving on.
`default_nettype none
module watering_pump_sequencer
	import wps_pkg::*;
#(
	parameter int SAMPLES = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              evt_valid,
	output logic                   evt_ready,
	input  wire evt_t              evt,
	output logic                   stat_valid,
	input  wire logic              stat_ready,
	output stat_t                  stat,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	localparam int CNT_W  = $clog2(SAMPLES + 1);
	localparam int DIV_SH = SUM_W + $clog2(SAMPLES);
	localparam int RCP_W  = DIV_SH + 1;
	localparam logic [RCP_W-1:0] RCP = RCP_W'(((64'd1 << DIV_SH) / SAMPLES) + 1);
	localparam int PROD_W = SUM_W + RCP_W;

	cfg_t cfg;

	wps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	evt_t  evt_s1;
	logic  valid_s1;
	stat_t stat_q;
	logic  stat_valid_q;
	logic  move;

	phase_t             phase_q, ph_n;
	logic               active_q, act_n;
	logic [WAIT_W-1:0]  wait_q, wc_n, wc_inc;
	logic [7:0]         pump_ticks_q, pt_n;
	logic [SUM_W-1:0]   sum_q, sum_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n;
	logic [7:0]         prev_q, prev_n;
	logic [7:0]         cur_q, cur_n;
	logic [7:0]         goal_q, goal_n;
	logic [3:0]         fail_q, fail_n, fail_inc;
	logic               reload_q, reload_n;
	logic [PROD_W-1:0]  prod;
	logic               do_setup, do_end_setup, do_pump, do_idle, do_measure;
	stat_t              stat_n;

	assign move       = valid_s1 & (~stat_valid_q | stat_ready);
	assign evt_ready  = ~valid_s1 | move;
	assign stat_valid = stat_valid_q;
	assign stat       = stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_ready) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_ready && evt_valid) begin
			evt_s1 <= evt;
		end
	end

	always_comb begin
		ph_n         = phase_q;
		act_n        = active_q;
		wc_n         = wait_q;
		pt_n         = pump_ticks_q;
		sum_n        = sum_q;
		cnt_n        = cnt_q;
		prev_n       = prev_q;
		cur_n        = cur_q;
		goal_n       = goal_q;
		fail_n       = fail_q;
		reload_n     = reload_q;
		do_setup     = 1'b0;
		do_end_setup = 1'b0;
		do_pump      = 1'b0;
		do_idle      = 1'b0;
		do_measure   = 1'b0;
		wc_inc       = wait_q + 1'b1;
		fail_inc     = (fail_q == FAIL_MAX) ? FAIL_MAX : fail_q + 1'b1;
		prod         = '0;

		case (evt_s1.op)
			OP_TICK: begin
				if (phase_q == PH_SETUP) begin
					wc_n = wc_inc;
					if (wc_inc >= {4'd0, cfg.setup_limit}) begin
						do_end_setup = 1'b1;
					end
				end else if (phase_q == PH_SETTLE || phase_q == PH_PUMP
						|| phase_q == PH_IDLE) begin
					if (wait_q <= WAIT_W'(1)) begin
						wc_n = '0;
						if (phase_q == PH_SETTLE) begin
							ph_n = PH_SAMPLE;
						end else if (phase_q == PH_PUMP) begin
							do_idle = 1'b1;
						end else begin
							do_measure = 1'b1;
						end
					end else begin
						wc_n = wait_q - 1'b1;
					end
				end
			end
			OP_SAMPLE: begin
				if (phase_q == PH_SAMPLE) begin
					sum_n = sum_q + {4'd0, evt_s1.sample};
					cnt_n = cnt_q + 1'b1;
					if (cnt_n >= CNT_W'(SAMPLES)) begin
						prod   = PROD_W'(sum_n) * PROD_W'(RCP);
						prev_n = cur_q;
						cur_n  = prod[DIV_SH +: 8];
						if (reload_q) begin
							goal_n   = cur_n;
							reload_n = 1'b0;
						end
						if (active_q) begin
							do_setup = 1'b1;
						end else if (cur_n > goal_n) begin
							if (cur_n >= cur_q && cur_q > goal_n) begin
								fail_n = fail_inc;
								if (fail_inc > cfg.failure_limit) begin
									ph_n = PH_WAIT;
								end else begin
									do_pump = 1'b1;
								end
							end else begin
								fail_n  = '0;
								do_pump = 1'b1;
							end
						end else begin
							fail_n  = '0;
							do_idle = 1'b1;
						end
					end
				end
			end
			OP_BUTTON: begin
				act_n = evt_s1.button_pressed;
				if (evt_s1.button_pressed) begin
					if (phase_q == PH_WAIT || phase_q == PH_PUMP || phase_q == PH_IDLE) begin
						do_setup = 1'b1;
					end
				end else if (phase_q == PH_SETUP) begin
					do_end_setup = 1'b1;
				end
			end
			OP_NONE: ;
			default: ;
		endcase

		if (do_setup) begin
			ph_n = PH_SETUP;
			wc_n = '0;
			if (cfg.setup_limit == 8'd0) begin
				do_end_setup = 1'b1;
			end
		end
		if (do_end_setup) begin
			pt_n       = wc_n[7:0];
			act_n      = 1'b0;
			reload_n   = 1'b1;
			do_measure = 1'b1;
		end
		if (do_pump) begin
			if (pt_n == 8'd0) begin
				do_idle = 1'b1;
			end else begin
				wc_n = {4'd0, pt_n};
				ph_n = PH_PUMP;
			end
		end
		if (do_idle) begin
			if (cfg.idle_ticks == 12'd0) begin
				do_measure = 1'b1;
			end else begin
				wc_n = cfg.idle_ticks;
				ph_n = PH_IDLE;
			end
		end
		if (do_measure) begin
			sum_n = '0;
			cnt_n = '0;
			wc_n  = {4'd0, cfg.settle_ticks};
			ph_n  = (cfg.settle_ticks == 8'd0) ? PH_SAMPLE : PH_SETTLE;
		end
	end

	always_comb begin
		stat_n.pump_drive   = (ph_n == PH_SETUP) || (ph_n == PH_PUMP);
		stat_n.sensor_drive = (ph_n == PH_SETTLE) || (ph_n == PH_SAMPLE);
		stat_n.sampling     = (ph_n == PH_SAMPLE);
		stat_n.level        = cur_n;
		stat_n.goal_level   = goal_n;
		case (ph_n)
			PH_WAIT:   stat_n.phase_code = CODE_WAIT;
			PH_SETUP:  stat_n.phase_code = CODE_SETUP;
			PH_SETTLE: stat_n.phase_code = CODE_SETTLE;
			PH_SAMPLE: stat_n.phase_code = CODE_SAMPLE;
			PH_PUMP:   stat_n.phase_code = CODE_PUMP;
			PH_IDLE:   stat_n.phase_code = CODE_IDLE;
			default:   stat_n.phase_code = CODE_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_WAIT;
			active_q     <= 1'b0;
			wait_q       <= '0;
			pump_ticks_q <= '0;
			sum_q        <= '0;
			cnt_q        <= '0;
			prev_q       <= '0;
			cur_q        <= '0;
			goal_q       <= '0;
			fail_q       <= '0;
			reload_q     <= 1'b0;
		end else if (move) begin
			phase_q      <= ph_n;
			active_q     <= act_n;
			wait_q       <= wc_n;
			pump_ticks_q <= pt_n;
			sum_q        <= sum_n;
			cnt_q        <= cnt_n;
			prev_q       <= prev_n;
			cur_q        <= cur_n;
			goal_q       <= goal_n;
			fail_q       <= fail_n;
			reload_q     <= reload_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_valid_q <= 1'b0;
		end else if (move) begin
			stat_valid_q <= 1'b1;
		end else if (stat_ready) begin
			stat_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			stat_q <= stat_n;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/wps_checker.sv -----
// Port-level checks of the watering pump sequencer and their bind
`default_nettype none
`include "watering_pump_sequencer_assert.svh"
module wps_checker
	import wps_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	input wire logic  stat_valid,
	input wire logic  stat_ready,
	input wire stat_t stat
);

	logic pump_ok;
	logic sensor_ok;

	assign pump_ok   = stat.pump_drive ==
		((stat.phase_code == CODE_SETUP) || (stat.phase_code == CODE_PUMP));
	assign sensor_ok = (stat.sampling == (stat.phase_code == CODE_SAMPLE)) &&
		(stat.sensor_drive ==
		((stat.phase_code == CODE_SETTLE) || (stat.phase_code == CODE_SAMPLE)));

	`WPS_ASSERT_NEXT(a_stat_hold_valid, stat_valid && !stat_ready, stat_valid)
	`WPS_ASSERT_NEXT(a_stat_hold_data, stat_valid && !stat_ready, $stable(stat))
	`WPS_ASSERT_HOLD(a_pump_phase, stat_valid, pump_ok)
	`WPS_ASSERT_HOLD(a_sensor_phase, stat_valid, sensor_ok)

endmodule

bind watering_pump_sequencer wps_checker u_wps_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.stat_valid (stat_valid),
	.stat_ready (stat_ready),
	.stat       (stat)
);
`default_nettype wire
